FILE: hw/rtl/assert_macros.svh
// assertion helpers, sampled on the rising clock edge and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that must hold on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// a condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/srt_pkg.sv
package srt_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_MATCH     = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;
  localparam logic [2:0] ST_DELETED   = 3'd5;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] name;
    logic [31:0] tag;
  } rec_t;

endpackage

FILE: hw/rtl/srt_store.sv
module srt_store
  import srt_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  rec_t             wdata,
  input  logic [IDX_W-1:0] raddr,
  output rec_t             rdata
);

  rec_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/sorted_record_table_core.sv
// insert: a binary search over the stored keys, then each entry above the slot moves up
//   one at a time; the duplicate check runs only when some entry would move
// search and delete scan all n stored records; an insert into a full table skips the search
// throughput: one item at a time on one read port and one shared compare unit
// reset clears the record count and the sequencer; record contents stay unknown until written
// the receiver cannot stall: each result beat is shown for one cycle with valid high
module sorted_record_table_core
  import srt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [63:0] key,
  input  logic [63:0] name,
  input  logic [31:0] tag,
  output logic        valid,
  output logic [2:0]  status,
  output logic [63:0] out_key,
  output logic [63:0] out_name,
  output logic [31:0] out_tag,
  output logic        last
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_CHK,
    S_SHIFT,
    S_SHIFT_WR,
    S_SCAN,
    S_SCAN_CMP
  } state_t;

  state_t     state;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] mid_next;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] w;
  logic [1:0]       op_mode;
  rec_t             op_rec;
  logic             pend_hit;
  rec_t             pend_rec;

  logic             we;
  logic [IDX_W-1:0] waddr;
  rec_t             wdata;
  logic [IDX_W-1:0] raddr;
  rec_t             rdata;
  logic [CNT_W-1:0] i_dec;
  logic [63:0]      cmp_a;
  logic [63:0]      cmp_b;
  logic             cmp_lt;
  logic             cmp_eq;

  srt_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy     = (state != S_IDLE);
  assign mid_next = lo + ((hi - lo) >> 1);
  assign i_dec    = i - CNT_W'(1);

  // one compare unit: keys during insert, names during search and delete
  assign cmp_a  = (op_mode == MODE_INSERT) ? rdata.key : rdata.name;
  assign cmp_b  = (op_mode == MODE_INSERT) ? op_rec.key : op_rec.name;
  assign cmp_lt = (cmp_a < cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

  always_comb begin
    we    = 1'b0;
    waddr = w[IDX_W-1:0];
    wdata = rdata;
    raddr = i[IDX_W-1:0];
    unique case (state)
      S_SEARCH: begin
        raddr = (lo < hi) ? mid_next[IDX_W-1:0] : lo[IDX_W-1:0];
      end
      S_SHIFT: begin
        raddr = i_dec[IDX_W-1:0];
        if (i <= lo) begin
          we    = 1'b1;
          waddr = lo[IDX_W-1:0];
          wdata = op_rec;
        end
      end
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = i[IDX_W-1:0];
      end
      S_SCAN_CMP: begin
        // compaction: keep non-matching records, packed down to slot w
        we = (op_mode == MODE_DELETE) && !cmp_eq;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    valid <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      pend_hit <= 1'b0;
      last     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_mode     <= mode;
            op_rec.key  <= key;
            op_rec.name <= name;
            op_rec.tag  <= tag;
            i           <= '0;
            w           <= '0;
            pend_hit    <= 1'b0;
            lo          <= '0;
            hi          <= fill;
            unique case (mode)
              MODE_INSERT: begin
                if (fill == CNT_W'(CAPACITY)) begin
                  valid    <= 1'b1;
                  status   <= ST_FULL;
                  out_key  <= '0;
                  out_name <= '0;
                  out_tag  <= '0;
                  last     <= 1'b1;
                end else begin
                  state <= S_SEARCH;
                end
              end
              MODE_SEARCH, MODE_DELETE: state <= S_SCAN;
              default: begin
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= S_CMP;
          end else if (lo < fill) begin
            state <= S_CHK;
          end else begin
            i     <= fill;
            state <= S_SHIFT;
          end
        end
        S_CMP: begin
          if (cmp_lt) begin
            lo <= mid + CNT_W'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SEARCH;
        end
        S_CHK: begin
          if (cmp_eq) begin
            valid    <= 1'b1;
            status   <= ST_DUPLICATE;
            out_key  <= '0;
            out_name <= '0;
            out_tag  <= '0;
            last     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            i     <= fill;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (i > lo) begin
            state <= S_SHIFT_WR;
          end else begin
            fill     <= fill + CNT_W'(1);
            valid    <= 1'b1;
            status   <= ST_INSERTED;
            out_key  <= '0;
            out_name <= '0;
            out_tag  <= '0;
            last     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_SHIFT_WR: begin
          i     <= i_dec;
          state <= S_SHIFT;
        end
        S_SCAN: begin
          if (i < fill) begin
            i     <= i + CNT_W'(1);
            state <= S_SCAN_CMP;
          end else begin
            // end of table: flush the held match, or report none, as the final beat
            valid <= 1'b1;
            last  <= 1'b1;
            if (pend_hit) begin
              status   <= (op_mode == MODE_DELETE) ? ST_DELETED : ST_MATCH;
              out_key  <= pend_rec.key;
              out_name <= (op_mode == MODE_DELETE) ? '0 : pend_rec.name;
              out_tag  <= (op_mode == MODE_DELETE) ? '0 : pend_rec.tag;
            end else begin
              status   <= ST_NONE;
              out_key  <= '0;
              out_name <= '0;
              out_tag  <= '0;
            end
            if (op_mode == MODE_DELETE) begin
              fill <= w;
            end
            state <= S_IDLE;
          end
        end
        S_SCAN_CMP: begin
          if (cmp_eq) begin
            // a match is held back one step so the final one can carry last
            if (pend_hit) begin
              valid    <= 1'b1;
              last     <= 1'b0;
              status   <= (op_mode == MODE_DELETE) ? ST_DELETED : ST_MATCH;
              out_key  <= pend_rec.key;
              out_name <= (op_mode == MODE_DELETE) ? '0 : pend_rec.name;
              out_tag  <= (op_mode == MODE_DELETE) ? '0 : pend_rec.tag;
            end
            pend_hit <= 1'b1;
            pend_rec <= rdata;
          end else begin
            w <= w + CNT_W'(1);
          end
          state <= S_SCAN;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_fill_bound, fill <= CNT_W'(CAPACITY), "record count above capacity")
  `ASSERT_CLK(a_last_idle, valid && last |-> !busy, "final beat while still busy")
  `ASSERT_NEVER(a_early_idle, valid && !last && !busy, "non-final beat after operation end")
  `ASSERT_CLK(a_insert_count, valid && status == ST_INSERTED |-> fill == $past(fill) + CNT_W'(1),
    "insert did not grow the table by one")

endmodule

FILE: tb/tb.sv
module tb;
  import srt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic [63:0] NAME_BOB     = 64'h424F_4200_0000_0000;
  localparam logic [63:0] NAME_BOB_PAD = 64'h424F_4200_0000_0001;
  localparam logic [63:0] NAME_ALICE   = 64'h414C_4943_4500_0000;
  localparam logic [63:0] NAME_ZED     = 64'h5A45_4400_0000_0000;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] key;
    logic [63:0] name;
    logic [31:0] tag;
    logic        last;
  } table_beat_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] name;
    logic [31:0] tag;
    bit          typed;
    logic [2:0]  typed_status;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = MODE_INSERT;
  logic [63:0] key = '0;
  logic [63:0] name = '0;
  logic [31:0] tag = '0;
  logic        valid;
  logic [2:0]  status;
  logic [63:0] out_key;
  logic [63:0] out_name;
  logic [31:0] out_tag;
  logic        last;

  // predictor copy of the table
  logic [63:0] table_keys [CAPACITY];
  logic [63:0] table_names [CAPACITY];
  logic [31:0] table_tags [CAPACITY];
  int          table_fill = 0;

  table_beat_t awaiting_beats [$];
  op_row_t     directed_rows [$];
  table_beat_t got_beat;
  int          errors = 0;
  int          quiet_cycles = 0;

  sorted_record_table_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .key      (key),
    .name     (name),
    .tag      (tag),
    .valid    (valid),
    .status   (status),
    .out_key  (out_key),
    .out_name (out_name),
    .out_tag  (out_tag),
    .last     (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_row(input logic [1:0] m, input logic [63:0] k,
                                  input logic [63:0] n, input logic [31:0] t,
                                  input bit typed, input logic [2:0] st);
    op_row_t row;
    row.mode = m;
    row.key = k;
    row.name = n;
    row.tag = t;
    row.typed = typed;
    row.typed_status = st;
    directed_rows.push_back(row);
  endfunction

  // sorted insert, search by name, delete by name with compaction
  task automatic apply_table_op(input logic [1:0] op, input logic [63:0] k,
                                input logic [63:0] nm, input logic [31:0] tg,
                                input bit record);
    int lo;
    int hi;
    int mid;
    int w;
    table_beat_t beat;
    table_beat_t found [$];
    beat = '0;
    if (op == MODE_INSERT) begin
      beat.last = 1'b1;
      if (table_fill >= CAPACITY) begin
        beat.status = ST_FULL;
      end else begin
        lo = 0;
        hi = table_fill;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (table_keys[mid] < k) lo = mid + 1;
          else hi = mid;
        end
        if (lo < table_fill && table_keys[lo] == k) begin
          beat.status = ST_DUPLICATE;
        end else begin
          for (int i = table_fill; i > lo; i--) begin
            table_keys[i] = table_keys[i - 1];
            table_names[i] = table_names[i - 1];
            table_tags[i] = table_tags[i - 1];
          end
          table_keys[lo] = k;
          table_names[lo] = nm;
          table_tags[lo] = tg;
          table_fill++;
          beat.status = ST_INSERTED;
        end
      end
      found.push_back(beat);
    end else if (op == MODE_SEARCH || op == MODE_DELETE) begin
      w = 0;
      for (int i = 0; i < table_fill; i++) begin
        if (table_names[i] == nm) begin
          beat = '0;
          beat.key = table_keys[i];
          if (op == MODE_SEARCH) begin
            beat.status = ST_MATCH;
            beat.name = table_names[i];
            beat.tag = table_tags[i];
          end else begin
            beat.status = ST_DELETED;
          end
          found.push_back(beat);
        end else if (op == MODE_DELETE) begin
          table_keys[w] = table_keys[i];
          table_names[w] = table_names[i];
          table_tags[w] = table_tags[i];
          w++;
        end
      end
      if (op == MODE_DELETE) table_fill = w;
      if (found.size() == 0) begin
        beat = '0;
        beat.status = ST_NONE;
        beat.last = 1'b1;
        found.push_back(beat);
      end else begin
        found[found.size() - 1].last = 1'b1;
      end
    end
    if (record) begin
      foreach (found[i]) awaiting_beats.push_back(found[i]);
    end
  endtask

  // called right after a rising edge; returns at the edge that takes the beat
  task automatic send_op(input logic [1:0] m, input logic [63:0] k,
                         input logic [63:0] n, input logic [31:0] t,
                         input bit idle_on);
    int gap;
    gap = idle_on ? int'($urandom_range(4)) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    key <= k;
    name <= n;
    tag <= t;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  function automatic logic [63:0] pick_name();
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2, 3: return NAME_BOB;
      4: return NAME_BOB_PAD;
      5, 6: return NAME_ALICE;
      7: return NAME_ZED;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && valid === 1'b1) begin
      if (awaiting_beats.size() == 0) begin
        $error("unexpected result beat: status %0d out_key %h", status, out_key);
        errors++;
      end else begin
        got_beat = awaiting_beats.pop_front();
        if (status !== got_beat.status) begin
          $error("status expected %0d got %0d", got_beat.status, status);
          errors++;
        end
        if (out_key !== got_beat.key) begin
          $error("out_key expected %h got %h", got_beat.key, out_key);
          errors++;
        end
        if (out_name !== got_beat.name) begin
          $error("out_name expected %h got %h", got_beat.name, out_name);
          errors++;
        end
        if (out_tag !== got_beat.tag) begin
          $error("out_tag expected %h got %h", got_beat.tag, out_tag);
          errors++;
        end
        if (last !== got_beat.last) begin
          $error("last expected %0b got %0b", got_beat.last, last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    table_beat_t typed_beat;
    op_row_t row;
    logic [1:0] m;
    logic [63:0] k;
    int pct;
    int ins_pct;
    int srch_pct;
    int del_pct;
    int round_len;
    bit idle_on;

    // empty table, extremes, duplicates, padding, unused mode, deletes down to empty
    add_row(MODE_SEARCH, '0, '0, '0, 1, ST_NONE);
    add_row(MODE_DELETE, '0, '0, '0, 1, ST_NONE);
    add_row(MODE_INSERT, ALL_ONES, ALL_ONES, 32'hFFFF_FFFF, 1, ST_INSERTED);
    add_row(MODE_INSERT, '0, '0, '0, 1, ST_INSERTED);
    add_row(MODE_INSERT, ALL_ONES, NAME_BOB, 32'h1234_5678, 1, ST_DUPLICATE);
    add_row(MODE_INSERT, '0, NAME_BOB, 32'h0, 1, ST_DUPLICATE);
    add_row(MODE_INSERT, NAME_ALICE, NAME_BOB, 32'h6162_0000, 1, ST_INSERTED);
    // differs from the previous key only after the zero byte
    add_row(MODE_INSERT, NAME_ALICE | 64'h1, NAME_BOB_PAD, 32'h6364_0000, 1, ST_INSERTED);
    add_row(MODE_INSERT, 64'h1, NAME_BOB, 32'h5A5A_5A5A, 1, ST_INSERTED);
    add_row(MODE_SEARCH, '0, NAME_BOB, '0, 0, ST_NONE);
    add_row(MODE_SEARCH, '0, NAME_BOB_PAD, '0, 0, ST_NONE);
    add_row(MODE_SEARCH, '0, ALL_ONES, '0, 0, ST_NONE);
    add_row(MODE_SEARCH, '0, '0, '0, 0, ST_NONE);
    add_row(MODE_UNUSED, ALL_ONES, NAME_BOB, 32'hFFFF_FFFF, 0, ST_NONE);
    add_row(MODE_SEARCH, '0, NAME_ZED, '0, 1, ST_NONE);
    add_row(MODE_DELETE, ALL_ONES, NAME_BOB, 32'hFFFF_FFFF, 0, ST_NONE);
    add_row(MODE_DELETE, '0, NAME_BOB, '0, 1, ST_NONE);
    add_row(MODE_SEARCH, '0, NAME_BOB_PAD, '0, 0, ST_NONE);
    add_row(MODE_DELETE, '0, '0, '0, 0, ST_NONE);
    add_row(MODE_DELETE, '0, ALL_ONES, '0, 0, ST_NONE);
    add_row(MODE_DELETE, '0, NAME_BOB_PAD, '0, 0, ST_NONE);
    add_row(MODE_SEARCH, '0, ALL_ONES, '0, 1, ST_NONE);
    add_row(MODE_INSERT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
            32'h8000_0000, 1, ST_INSERTED);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_op(row.mode, row.key, row.name, row.tag, 1'b1);
      if (row.typed) begin
        typed_beat = '0;
        typed_beat.status = row.typed_status;
        typed_beat.last = 1'b1;
        awaiting_beats.push_back(typed_beat);
        apply_table_op(row.mode, row.key, row.name, row.tag, 1'b0);
      end else begin
        apply_table_op(row.mode, row.key, row.name, row.tag, 1'b1);
      end
    end

    // fill past capacity, a balanced mix, refill, then the same mix again
    for (int round = 0; round < 4; round++) begin
      case (round)
        0: begin ins_pct = 95; srch_pct = 95; del_pct = 95; round_len = 60; end
        2: begin ins_pct = 85; srch_pct = 92; del_pct = 97; round_len = 45; end
        default: begin ins_pct = 30; srch_pct = 65; del_pct = 95; round_len = 50; end
      endcase
      idle_on = (round != 2);
      for (int j = 0; j < round_len; j++) begin
        pct = $urandom_range(99);
        if (pct < ins_pct) m = MODE_INSERT;
        else if (pct < srch_pct) m = MODE_SEARCH;
        else if (pct < del_pct) m = MODE_DELETE;
        else m = MODE_UNUSED;
        case ($urandom_range(9))
          0, 1: k = (table_fill > 0) ? table_keys[$urandom_range(table_fill - 1)]
                                     : {$urandom, $urandom};
          2: k = $urandom_range(1) ? ALL_ONES : 64'h0;
          default: k = {$urandom, $urandom};
        endcase
        row.name = pick_name();
        row.tag = $urandom;
        send_op(m, k, row.name, row.tag, idle_on);
        apply_table_op(m, k, row.name, row.tag, 1'b1);
      end
    end
    start <= 1'b0;

    while (awaiting_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && awaiting_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
